[rtl/tsc_pkg.sv]
// Package for the touch sample calibrator: widths, reset values and codes.
// Shared by the channel interfaces and every module of the block.
// No dependencies.
`default_nettype none

package tsc_pkg;

	// Default converter resolution and fixed field widths.
	localparam int SAMPLE_BITS_DEF = 12;
	localparam int SIZE_W          = 12;
	localparam int POINT_W         = 16;
	localparam int TOUCH_LIMIT     = 300;

	// Register file layout.
	localparam int NUM_CFG   = 8;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_X_CAL_LOW       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_X_CAL_HIGH      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_CAL_LOW       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_CAL_HIGH      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_ROTATION = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_WIRING_VARIANT  = 3'd7;

	// Reset values of the screen size registers.
	localparam logic [SIZE_W-1:0] WIDTH_RST  = 12'd320;
	localparam logic [SIZE_W-1:0] HEIGHT_RST = 12'd240;

	// Rotation codes.
	localparam logic [1:0] ROT_0 = 2'd0;
	localparam logic [1:0] ROT_1 = 2'd1;
	localparam logic [1:0] ROT_2 = 2'd2;
	localparam logic [1:0] ROT_3 = 2'd3;

	// Wiring variants, each with its own rotation table.
	localparam logic WIRE_SPI     = 1'b0;
	localparam logic WIRE_BITBANG = 1'b1;

	// Divider lanes.
	localparam int LANES  = 2;
	localparam int LANE_X = 0;
	localparam int LANE_Y = 1;

endpackage

`default_nettype wire

[rtl/tsc_ifs.sv]
// Valid/ready channel interfaces for the touch sample calibrator.
// The sample channel carries one set of readings, the point channel one result.
// Depends on tsc_pkg.
`default_nettype none

interface tsc_in_if #(parameter int SAMPLE_BITS = tsc_pkg::SAMPLE_BITS_DEF) ();
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] raw_x;
	logic [SAMPLE_BITS-1:0] raw_y;
	logic [SAMPLE_BITS-1:0] pressure_one;
	logic [SAMPLE_BITS-1:0] pressure_two;

	modport source (output valid, raw_x, raw_y, pressure_one, pressure_two, input ready);
	modport sink (input valid, raw_x, raw_y, pressure_one, pressure_two, output ready);
endinterface

interface tsc_out_if #(parameter int SAMPLE_BITS = tsc_pkg::SAMPLE_BITS_DEF) ();
	import tsc_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [POINT_W-1:0]   point_x;
	logic [POINT_W-1:0]   point_y;
	logic [SAMPLE_BITS:0] pressure;
	logic                 touched;
	logic                 cal_error;

	modport source (output valid, point_x, point_y, pressure, touched, cal_error,
		input ready);
	modport sink (input valid, point_x, point_y, pressure, touched, cal_error,
		output ready);
endinterface

`default_nettype wire

[rtl/tsc_front.sv]
// Front end of the calibrator: pressure, rotation, offset removal and scaling.
// Two pipeline stages that feed the numerator and divisor of each axis.
// Depends on tsc_pkg and tsc_ifs.
`default_nettype none

module tsc_front #(
	parameter int SAMPLE_BITS = tsc_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	tsc_in_if.sink                                 in_ch,
	input  logic                                   advance,
	input  logic [SAMPLE_BITS-1:0]                 x_cal_low,
	input  logic [SAMPLE_BITS-1:0]                 x_cal_high,
	input  logic [SAMPLE_BITS-1:0]                 y_cal_low,
	input  logic [SAMPLE_BITS-1:0]                 y_cal_high,
	input  logic [1:0]                             screen_rotation,
	input  logic                                   wiring_variant,
	input  logic [tsc_pkg::SIZE_W-1:0]             screen_width,
	input  logic [tsc_pkg::SIZE_W-1:0]             screen_height,
	output logic                                   valid_s2,
	output logic [SAMPLE_BITS+tsc_pkg::SIZE_W-1:0] num_x_s2,
	output logic [SAMPLE_BITS+tsc_pkg::SIZE_W-1:0] num_y_s2,
	output logic [SAMPLE_BITS-1:0]                 den_x_s2,
	output logic [SAMPLE_BITS-1:0]                 den_y_s2,
	output logic                                   neg_x_s2,
	output logic                                   neg_y_s2,
	output logic                                   zero_x_s2,
	output logic                                   zero_y_s2,
	output logic [SAMPLE_BITS:0]                   press_s2,
	output logic                                   touched_s2
);
	import tsc_pkg::*;

	localparam int NUM_W = SAMPLE_BITS + SIZE_W;

	// Stage one combinational signals.
	logic [SAMPLE_BITS:0]   press_c;
	logic                   touched_c;
	logic [SAMPLE_BITS-1:0] xr_c;
	logic [SAMPLE_BITS-1:0] yr_c;
	logic [SAMPLE_BITS:0]   dx_c;
	logic [SAMPLE_BITS:0]   dy_c;
	logic [SAMPLE_BITS:0]   sx_c;
	logic [SAMPLE_BITS:0]   sy_c;
	logic [SAMPLE_BITS:0]   mdx_c;
	logic [SAMPLE_BITS:0]   mdy_c;
	logic [SAMPLE_BITS:0]   msx_c;
	logic [SAMPLE_BITS:0]   msy_c;

	// Stage one registers.
	logic                   valid_s1;
	logic [SAMPLE_BITS-1:0] mag_dx_s1;
	logic [SAMPLE_BITS-1:0] mag_dy_s1;
	logic [SAMPLE_BITS-1:0] mag_sx_s1;
	logic [SAMPLE_BITS-1:0] mag_sy_s1;
	logic                   neg_dx_s1;
	logic                   neg_dy_s1;
	logic                   neg_sx_s1;
	logic                   neg_sy_s1;
	logic [SAMPLE_BITS:0]   press_s1;
	logic                   touched_s1;

	assign in_ch.ready = advance;

	// Pressure is Z1 plus full scale minus Z2; it never goes negative.
	assign press_c = {1'b0, in_ch.pressure_one} + {1'b0, {SAMPLE_BITS{1'b1}}}
		- {1'b0, in_ch.pressure_two};
	assign touched_c = press_c > (SAMPLE_BITS + 1)'(TOUCH_LIMIT);

	// Rotation tables; the full-scale complement of a reading is its inverse.
	always_comb begin
		xr_c = in_ch.raw_x;
		yr_c = in_ch.raw_y;
		case (wiring_variant)
			WIRE_SPI: begin
				case (screen_rotation)
					ROT_0: begin
						xr_c = ~in_ch.raw_x;
						yr_c = in_ch.raw_y;
					end
					ROT_1: begin
						xr_c = in_ch.raw_y;
						yr_c = in_ch.raw_x;
					end
					ROT_2: begin
						xr_c = in_ch.raw_x;
						yr_c = ~in_ch.raw_y;
					end
					ROT_3: begin
						xr_c = ~in_ch.raw_y;
						yr_c = ~in_ch.raw_x;
					end
					default: begin
						xr_c = in_ch.raw_x;
						yr_c = in_ch.raw_y;
					end
				endcase
			end
			WIRE_BITBANG: begin
				case (screen_rotation)
					ROT_0: begin
						xr_c = ~in_ch.raw_y;
						yr_c = in_ch.raw_x;
					end
					ROT_1: begin
						xr_c = in_ch.raw_x;
						yr_c = in_ch.raw_y;
					end
					ROT_2: begin
						xr_c = in_ch.raw_y;
						yr_c = ~in_ch.raw_x;
					end
					ROT_3: begin
						xr_c = ~in_ch.raw_x;
						yr_c = ~in_ch.raw_y;
					end
					default: begin
						xr_c = in_ch.raw_x;
						yr_c = in_ch.raw_y;
					end
				endcase
			end
			default: begin
				xr_c = in_ch.raw_x;
				yr_c = in_ch.raw_y;
			end
		endcase
	end

	// Offsets and spans as signed values, then split into sign and magnitude.
	assign dx_c = {1'b0, xr_c} - {1'b0, x_cal_low};
	assign dy_c = {1'b0, yr_c} - {1'b0, y_cal_low};
	assign sx_c = {1'b0, x_cal_high} - {1'b0, x_cal_low};
	assign sy_c = {1'b0, y_cal_high} - {1'b0, y_cal_low};

	assign mdx_c = dx_c[SAMPLE_BITS] ? (~dx_c + 1'b1) : dx_c;
	assign mdy_c = dy_c[SAMPLE_BITS] ? (~dy_c + 1'b1) : dy_c;
	assign msx_c = sx_c[SAMPLE_BITS] ? (~sx_c + 1'b1) : sx_c;
	assign msy_c = sy_c[SAMPLE_BITS] ? (~sy_c + 1'b1) : sy_c;

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_ch.valid;
			valid_s2 <= valid_s1;
		end
	end

	// Stage one payload: magnitudes and signs.
	always_ff @(posedge clk) begin
		if (advance) begin
			mag_dx_s1  <= mdx_c[SAMPLE_BITS-1:0];
			mag_dy_s1  <= mdy_c[SAMPLE_BITS-1:0];
			mag_sx_s1  <= msx_c[SAMPLE_BITS-1:0];
			mag_sy_s1  <= msy_c[SAMPLE_BITS-1:0];
			neg_dx_s1  <= dx_c[SAMPLE_BITS];
			neg_dy_s1  <= dy_c[SAMPLE_BITS];
			neg_sx_s1  <= sx_c[SAMPLE_BITS];
			neg_sy_s1  <= sy_c[SAMPLE_BITS];
			press_s1   <= press_c;
			touched_s1 <= touched_c;
		end
	end

	// Stage two payload: one multiplier per axis scales the offset.
	always_ff @(posedge clk) begin
		if (advance) begin
			num_x_s2   <= NUM_W'(mag_dx_s1) * NUM_W'(screen_width);
			num_y_s2   <= NUM_W'(mag_dy_s1) * NUM_W'(screen_height);
			den_x_s2   <= mag_sx_s1;
			den_y_s2   <= mag_sy_s1;
			neg_x_s2   <= neg_dx_s1 ^ neg_sx_s1;
			neg_y_s2   <= neg_dy_s1 ^ neg_sy_s1;
			zero_x_s2  <= (mag_sx_s1 == '0);
			zero_y_s2  <= (mag_sy_s1 == '0);
			press_s2   <= press_s1;
			touched_s2 <= touched_s1;
		end
	end

endmodule

`default_nettype wire

[rtl/tsc_div.sv]
// Pipelined restoring divider for both axes, one quotient bit per stage.
// Carries a sideband vector alongside the quotients.
// Depends on tsc_pkg.
`default_nettype none

module tsc_div #(
	parameter int NUM_W  = 24,
	parameter int DEN_W  = 12,
	parameter int SIDE_W = 1
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 advance,
	input  logic                                 in_valid,
	input  logic [tsc_pkg::LANES-1:0][NUM_W-1:0] num,
	input  logic [tsc_pkg::LANES-1:0][DEN_W-1:0] den,
	input  logic [SIDE_W-1:0]                    side_in,
	output logic                                 out_valid,
	output logic [tsc_pkg::LANES-1:0][NUM_W-1:0] quo,
	output logic [SIDE_W-1:0]                    side_out
);
	import tsc_pkg::*;

	// Per-stage registers; the shift register holds the remaining dividend
	// bits in its upper part and the quotient bits found so far below them.
	logic                                valid_s [NUM_W];
	logic [LANES-1:0][DEN_W-1:0]         rem_s   [NUM_W];
	logic [LANES-1:0][NUM_W-1:0]         quo_s   [NUM_W];
	logic [LANES-1:0][DEN_W-1:0]         den_s   [NUM_W];
	logic [SIDE_W-1:0]                   side_s  [NUM_W];

	for (genvar k = 0; k < NUM_W; k++) begin : g_stage
		logic                        valid_in;
		logic [LANES-1:0][DEN_W-1:0] rem_in;
		logic [LANES-1:0][NUM_W-1:0] quo_in;
		logic [LANES-1:0][DEN_W-1:0] den_in;
		logic [SIDE_W-1:0]           side_in_k;
		logic [LANES-1:0][DEN_W-1:0] rem_nx;
		logic [LANES-1:0][NUM_W-1:0] quo_nx;

		if (k == 0) begin : g_first
			assign valid_in  = in_valid;
			assign rem_in    = '0;
			assign quo_in    = num;
			assign den_in    = den;
			assign side_in_k = side_in;
		end else begin : g_next
			assign valid_in  = valid_s[k-1];
			assign rem_in    = rem_s[k-1];
			assign quo_in    = quo_s[k-1];
			assign den_in    = den_s[k-1];
			assign side_in_k = side_s[k-1];
		end

		// One trial subtraction per lane.
		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic [DEN_W:0]   trial;
			logic [DEN_W+1:0] diff;

			assign trial     = {rem_in[l], quo_in[l][NUM_W-1]};
			assign diff      = {1'b0, trial} - {2'b00, den_in[l]};
			assign rem_nx[l] = diff[DEN_W+1] ? trial[DEN_W-1:0] : diff[DEN_W-1:0];
			assign quo_nx[l] = {quo_in[l][NUM_W-2:0], ~diff[DEN_W+1]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (advance) begin
				valid_s[k] <= valid_in;
			end
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				rem_s[k]  <= rem_nx;
				quo_s[k]  <= quo_nx;
				den_s[k]  <= den_in;
				side_s[k] <= side_in_k;
			end
		end
	end

	assign out_valid = valid_s[NUM_W-1];
	assign quo       = quo_s[NUM_W-1];
	assign side_out  = side_s[NUM_W-1];

endmodule

`default_nettype wire

[rtl/tsc_out_buf.sv]
// Output stage: sign fix-up, bounds test and a two-entry skid buffer.
// Drives the point channel and the pipeline advance enable.
// Depends on tsc_pkg and tsc_ifs.
`default_nettype none

module tsc_out_buf #(
	parameter int SAMPLE_BITS = tsc_pkg::SAMPLE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	tsc_out_if.source                   out_ch,
	output logic                        advance,
	input  logic                        in_valid,
	input  logic [tsc_pkg::POINT_W-1:0] quo_x,
	input  logic [tsc_pkg::POINT_W-1:0] quo_y,
	input  logic                        neg_x,
	input  logic                        neg_y,
	input  logic                        zero_x,
	input  logic                        zero_y,
	input  logic [SAMPLE_BITS:0]        press,
	input  logic                        touched,
	input  logic [tsc_pkg::SIZE_W-1:0]  screen_width,
	input  logic [tsc_pkg::SIZE_W-1:0]  screen_height
);
	import tsc_pkg::*;

	logic [POINT_W-1:0]   px_c;
	logic [POINT_W-1:0]   py_c;
	logic                 oob_c;
	logic [SAMPLE_BITS:0] pout_c;
	logic                 load;
	logic                 out_free;

	logic                 out_valid_q;
	logic [POINT_W-1:0]   out_px_q;
	logic [POINT_W-1:0]   out_py_q;
	logic [SAMPLE_BITS:0] out_press_q;
	logic                 out_touched_q;
	logic                 out_err_q;

	logic                 skid_valid_q;
	logic [POINT_W-1:0]   skid_px_q;
	logic [POINT_W-1:0]   skid_py_q;
	logic [SAMPLE_BITS:0] skid_press_q;
	logic                 skid_touched_q;
	logic                 skid_err_q;

	// Signed quotient from magnitude; a zero span gives a coordinate of zero.
	assign px_c = zero_x ? '0 : (neg_x ? (~quo_x + 1'b1) : quo_x);
	assign py_c = zero_y ? '0 : (neg_y ? (~quo_y + 1'b1) : quo_y);

	// Points outside the open screen rectangle report no pressure.
	assign oob_c = (px_c >= POINT_W'(screen_width)) || (px_c == '0)
		|| (py_c >= POINT_W'(screen_height)) || (py_c == '0);
	assign pout_c = oob_c ? '0 : press;

	// The pipeline moves unless the skid entry is holding a beat.
	assign advance  = ~skid_valid_q;
	assign load     = advance & in_valid;
	assign out_free = ~out_valid_q | out_ch.ready;

	// Occupancy of the output and skid entries.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q | load;
			skid_valid_q <= 1'b0;
		end else if (load) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload of the output and skid entries.
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_px_q      <= skid_px_q;
				out_py_q      <= skid_py_q;
				out_press_q   <= skid_press_q;
				out_touched_q <= skid_touched_q;
				out_err_q     <= skid_err_q;
			end else if (load) begin
				out_px_q      <= px_c;
				out_py_q      <= py_c;
				out_press_q   <= pout_c;
				out_touched_q <= touched;
				out_err_q     <= zero_x | zero_y;
			end
		end else if (load) begin
			skid_px_q      <= px_c;
			skid_py_q      <= py_c;
			skid_press_q   <= pout_c;
			skid_touched_q <= touched;
			skid_err_q     <= zero_x | zero_y;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.point_x   = out_px_q;
	assign out_ch.point_y   = out_py_q;
	assign out_ch.pressure  = out_press_q;
	assign out_ch.touched   = out_touched_q;
	assign out_ch.cal_error = out_err_q;

endmodule

`default_nettype wire

[rtl/touch_sample_calibrator_unit.sv]
// Top level of the touch sample calibrator: register file and pipeline wiring.
// Instantiates tsc_front, tsc_div and tsc_out_buf.
// Depends on tsc_pkg and tsc_ifs.
//
//   Port            Direction  Carries
//   in_ch           sink       raw_x, raw_y, pressure_one, pressure_two
//   out_ch          source     point_x, point_y, pressure, touched, cal_error
//   cfg_wr_en/...   write      register index and data, no read-back
//
// One sample is accepted per cycle while the pipeline is not held, and each
// gives one point after two front stages, one divider stage per numerator bit
// and the output register.
// Reset clears the valid bits and loads the register reset values.
// A stalled output holds the pipeline once its skid entry is full; no beat is
// lost or repeated.
`default_nettype none

module touch_sample_calibrator_unit #(
	parameter int SAMPLE_BITS = tsc_pkg::SAMPLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	tsc_in_if.sink                            in_ch,
	tsc_out_if.source                         out_ch,
	input  logic                              cfg_wr_en,
	input  logic [tsc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [((SAMPLE_BITS > tsc_pkg::SIZE_W) ?
		SAMPLE_BITS : tsc_pkg::SIZE_W)-1:0]   cfg_wr_data
);
	import tsc_pkg::*;

	localparam int NUM_W  = SAMPLE_BITS + SIZE_W;
	localparam int SIDE_W = SAMPLE_BITS + 6;

	// Configuration registers.
	logic [SAMPLE_BITS-1:0] x_cal_low_q;
	logic [SAMPLE_BITS-1:0] x_cal_high_q;
	logic [SAMPLE_BITS-1:0] y_cal_low_q;
	logic [SAMPLE_BITS-1:0] y_cal_high_q;
	logic [1:0]             rotation_q;
	logic [SIZE_W-1:0]      width_q;
	logic [SIZE_W-1:0]      height_q;
	logic                   wiring_q;

	// Pipeline interconnect.
	logic                         advance;
	logic                         valid_s2;
	logic [NUM_W-1:0]             num_x_s2;
	logic [NUM_W-1:0]             num_y_s2;
	logic [SAMPLE_BITS-1:0]       den_x_s2;
	logic [SAMPLE_BITS-1:0]       den_y_s2;
	logic                         neg_x_s2;
	logic                         neg_y_s2;
	logic                         zero_x_s2;
	logic                         zero_y_s2;
	logic [SAMPLE_BITS:0]         press_s2;
	logic                         touched_s2;
	logic [LANES-1:0][NUM_W-1:0]  div_num;
	logic [LANES-1:0][SAMPLE_BITS-1:0] div_den;
	logic [LANES-1:0][NUM_W-1:0]  div_quo;
	logic [SIDE_W-1:0]            side_in;
	logic [SIDE_W-1:0]            side_out;
	logic                         div_valid;

	// Register writes; data is cut to each register's width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_cal_low_q  <= '0;
			x_cal_high_q <= '1;
			y_cal_low_q  <= '0;
			y_cal_high_q <= '1;
			rotation_q   <= ROT_0;
			width_q      <= WIDTH_RST;
			height_q     <= HEIGHT_RST;
			wiring_q     <= WIRE_SPI;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_X_CAL_LOW:       x_cal_low_q  <= cfg_wr_data[SAMPLE_BITS-1:0];
				CFG_X_CAL_HIGH:      x_cal_high_q <= cfg_wr_data[SAMPLE_BITS-1:0];
				CFG_Y_CAL_LOW:       y_cal_low_q  <= cfg_wr_data[SAMPLE_BITS-1:0];
				CFG_Y_CAL_HIGH:      y_cal_high_q <= cfg_wr_data[SAMPLE_BITS-1:0];
				CFG_SCREEN_ROTATION: rotation_q   <= cfg_wr_data[1:0];
				CFG_SCREEN_WIDTH:    width_q      <= cfg_wr_data[SIZE_W-1:0];
				CFG_SCREEN_HEIGHT:   height_q     <= cfg_wr_data[SIZE_W-1:0];
				CFG_WIRING_VARIANT:  wiring_q     <= cfg_wr_data[0];
				default: begin
				end
			endcase
		end
	end

	tsc_front #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_ch           (in_ch),
		.advance         (advance),
		.x_cal_low       (x_cal_low_q),
		.x_cal_high      (x_cal_high_q),
		.y_cal_low       (y_cal_low_q),
		.y_cal_high      (y_cal_high_q),
		.screen_rotation (rotation_q),
		.wiring_variant  (wiring_q),
		.screen_width    (width_q),
		.screen_height   (height_q),
		.valid_s2        (valid_s2),
		.num_x_s2        (num_x_s2),
		.num_y_s2        (num_y_s2),
		.den_x_s2        (den_x_s2),
		.den_y_s2        (den_y_s2),
		.neg_x_s2        (neg_x_s2),
		.neg_y_s2        (neg_y_s2),
		.zero_x_s2       (zero_x_s2),
		.zero_y_s2       (zero_y_s2),
		.press_s2        (press_s2),
		.touched_s2      (touched_s2)
	);

	// Both axes share one divider pipeline; the flags ride alongside.
	assign div_num[LANE_X] = num_x_s2;
	assign div_num[LANE_Y] = num_y_s2;
	assign div_den[LANE_X] = den_x_s2;
	assign div_den[LANE_Y] = den_y_s2;
	assign side_in = {neg_x_s2, zero_x_s2, neg_y_s2, zero_y_s2, touched_s2, press_s2};

	tsc_div #(
		.NUM_W  (NUM_W),
		.DEN_W  (SAMPLE_BITS),
		.SIDE_W (SIDE_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.in_valid  (valid_s2),
		.num       (div_num),
		.den       (div_den),
		.side_in   (side_in),
		.out_valid (div_valid),
		.quo       (div_quo),
		.side_out  (side_out)
	);

	tsc_out_buf #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_out_buf (
		.clk           (clk),
		.arst_n        (arst_n),
		.out_ch        (out_ch),
		.advance       (advance),
		.in_valid      (div_valid),
		.quo_x         (div_quo[LANE_X][POINT_W-1:0]),
		.quo_y         (div_quo[LANE_Y][POINT_W-1:0]),
		.neg_x         (side_out[SIDE_W-1]),
		.zero_x        (side_out[SIDE_W-2]),
		.neg_y         (side_out[SIDE_W-3]),
		.zero_y        (side_out[SIDE_W-4]),
		.touched       (side_out[SAMPLE_BITS+1]),
		.press         (side_out[SAMPLE_BITS:0]),
		.screen_width  (width_q),
		.screen_height (height_q)
	);

endmodule

`default_nettype wire

[sim/tb_touch_sample_calibrator_unit.sv]
// Self-checking testbench for the touch sample calibrator top level.
// Holds a scoreboard class that predicts each point from the readings and the register
// copy, and plain tasks that drive the sample and register ports. Needs tsc_pkg, tsc_ifs.
`timescale 1ns / 100ps

module tb_touch_sample_calibrator_unit;
	import tsc_pkg::*;

	localparam int SW            = SAMPLE_BITS_DEF;
	localparam int FULL          = (1 << SW) - 1;
	localparam int PRESS_W       = SW + 1;
	localparam int CFG_W         = (SW > SIZE_W) ? SW : SIZE_W;
	localparam int RANDOM_ITEMS  = 1700;
	localparam int PHASES        = 12;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int REPORT_LIMIT  = 10;

	typedef struct packed {
		logic [SW-1:0] raw_x;
		logic [SW-1:0] raw_y;
		logic [SW-1:0] pressure_one;
		logic [SW-1:0] pressure_two;
	} sample_t;

	typedef struct packed {
		logic [POINT_W-1:0] point_x;
		logic [POINT_W-1:0] point_y;
		logic [PRESS_W-1:0] pressure;
		logic               touched;
		logic               cal_error;
	} point_t;

	typedef struct packed {
		logic [SW-1:0]     x_lo;
		logic [SW-1:0]     x_hi;
		logic [SW-1:0]     y_lo;
		logic [SW-1:0]     y_hi;
		logic [1:0]        rotation;
		logic [SIZE_W-1:0] width;
		logic [SIZE_W-1:0] height;
		logic              wiring;
	} cal_regs_t;

	// Predicts the point for every accepted sample and checks returned points in order.
	class point_scoreboard;
		cal_regs_t regs;
		point_t    expected_q[$];
		int        mismatches;

		function new();
			regs.x_lo     = '0;
			regs.x_hi     = SW'(FULL);
			regs.y_lo     = '0;
			regs.y_hi     = SW'(FULL);
			regs.rotation = ROT_0;
			regs.width    = WIDTH_RST;
			regs.height   = HEIGHT_RST;
			regs.wiring   = WIRE_SPI;
			mismatches    = 0;
		endfunction

		// Register writes keep only the bits that the register holds.
		function void load_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				CFG_X_CAL_LOW:       regs.x_lo = data[SW-1:0];
				CFG_X_CAL_HIGH:      regs.x_hi = data[SW-1:0];
				CFG_Y_CAL_LOW:       regs.y_lo = data[SW-1:0];
				CFG_Y_CAL_HIGH:      regs.y_hi = data[SW-1:0];
				CFG_SCREEN_ROTATION: regs.rotation = data[1:0];
				CFG_SCREEN_WIDTH:    regs.width = data[SIZE_W-1:0];
				CFG_SCREEN_HEIGHT:   regs.height = data[SIZE_W-1:0];
				CFG_WIRING_VARIANT:  regs.wiring = data[0];
				default: ;
			endcase
		endfunction

		// Scales one axis with a signed quotient truncated toward zero; a zero span
		// raises the error flag and gives a coordinate of zero.
		function logic [POINT_W-1:0] map_axis(longint raw, longint lo, longint hi,
			longint size, inout bit err);
			longint span;
			span = hi - lo;
			if (span == 0) begin
				err = 1'b1;
				return '0;
			end
			return POINT_W'(((raw - lo) * size) / span);
		endfunction

		function void note_sample(sample_t s);
			longint full_scale, rx, ry, xr, yr, press;
			bit     err;
			point_t p;
			full_scale = FULL;
			rx         = s.raw_x;
			ry         = s.raw_y;
			press      = longint'(s.pressure_one) + full_scale - longint'(s.pressure_two);

			// Each wiring variant has its own rotation table.
			if (regs.wiring == WIRE_SPI) begin
				case (regs.rotation)
					ROT_0: begin xr = full_scale - rx; yr = ry; end
					ROT_1: begin xr = ry; yr = rx; end
					ROT_2: begin xr = rx; yr = full_scale - ry; end
					default: begin xr = full_scale - ry; yr = full_scale - rx; end
				endcase
			end else begin
				case (regs.rotation)
					ROT_0: begin xr = full_scale - ry; yr = rx; end
					ROT_1: begin xr = rx; yr = ry; end
					ROT_2: begin xr = ry; yr = full_scale - rx; end
					default: begin xr = full_scale - rx; yr = full_scale - ry; end
				endcase
			end

			err = 1'b0;
			p.point_x = map_axis(xr, regs.x_lo, regs.x_hi, regs.width, err);
			p.point_y = map_axis(yr, regs.y_lo, regs.y_hi, regs.height, err);
			p.pressure = PRESS_W'(press);

			// Points outside the open screen rectangle report no pressure.
			if (p.point_x == 0 || p.point_x >= regs.width ||
				p.point_y == 0 || p.point_y >= regs.height) begin
				p.pressure = '0;
			end
			p.touched   = (press > TOUCH_LIMIT);
			p.cal_error = err;
			expected_q.push_back(p);
		endfunction

		function void check_point(point_t got);
			point_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: point x=%0d y=%0d with no sample outstanding",
						$time, got.point_x, got.point_y);
				return;
			end
			want = expected_q.pop_front();
			if (got.point_x !== want.point_x || got.point_y !== want.point_y ||
				got.pressure !== want.pressure || got.touched !== want.touched ||
				got.cal_error !== want.cal_error) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: expected x=%0d y=%0d p=%0d t=%0b e=%0b, got x=%0d y=%0d p=%0d t=%0b e=%0b",
						$time, want.point_x, want.point_y, want.pressure, want.touched,
						want.cal_error, got.point_x, got.point_y, got.pressure,
						got.touched, got.cal_error);
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wr_data;

	// Idling controls shared between the stimulus and the point receiver.
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;
	bit hold_req  = 1'b0;

	point_scoreboard sb = new();

	tsc_in_if  in_ch ();
	tsc_out_if out_ch ();

	touch_sample_calibrator_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.out_ch     (out_ch),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wr_data(cfg_wr_data)
	);

	// 12 ns clock.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Offers one sample, after a random gap unless sending is steady, and returns at the edge that takes it.
	task automatic send_sample(input sample_t s);
		int gap;
		int r;
		gap = 0;
		if (!tx_steady) begin
			r = $urandom_range(0, 99);
			if (r >= 93)
				gap = $urandom_range(10, 50);
			else if (r >= 55)
				gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid        <= 1'b1;
		in_ch.raw_x        <= s.raw_x;
		in_ch.raw_y        <= s.raw_y;
		in_ch.pressure_one <= s.pressure_one;
		in_ch.pressure_two <= s.pressure_two;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		sb.note_sample(s);
	endtask

	// Stops offering and waits until every predicted point has come back.
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_wr_en   <= 1'b1;
		cfg_index   <= idx;
		cfg_wr_data <= data;
		@(posedge clk);
		sb.load_reg(idx, data);
	endtask

	// Writes every register; the narrow ones get random junk above their width.
	task automatic apply_config(input cal_regs_t c);
		logic [CFG_W-1:0] junk;
		write_reg(CFG_X_CAL_LOW, CFG_W'(c.x_lo));
		write_reg(CFG_X_CAL_HIGH, CFG_W'(c.x_hi));
		write_reg(CFG_Y_CAL_LOW, CFG_W'(c.y_lo));
		write_reg(CFG_Y_CAL_HIGH, CFG_W'(c.y_hi));
		junk      = CFG_W'($urandom);
		junk[1:0] = c.rotation;
		write_reg(CFG_SCREEN_ROTATION, junk);
		write_reg(CFG_SCREEN_WIDTH, CFG_W'(c.width));
		write_reg(CFG_SCREEN_HEIGHT, CFG_W'(c.height));
		junk      = CFG_W'($urandom);
		junk[0]   = c.wiring;
		write_reg(CFG_WIRING_VARIANT, junk);
		cfg_wr_en <= 1'b0;
	endtask

	// Readings lean towards the ends of the converter range now and then.
	function automatic logic [SW-1:0] rand_reading();
		int r;
		r = $urandom_range(0, 15);
		if (r == 0)
			return '0;
		if (r == 1)
			return SW'(FULL);
		return SW'($urandom_range(0, FULL));
	endfunction

	// Point receiver: random stalls, quiet stretches, and one long hold-off on request.
	initial begin
		int stall_left;
		int r;
		stall_left   = 0;
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				out_ch.ready <= 1'b0;
				stall_left--;
			end else if (hold_req) begin
				hold_req     = 1'b0;
				stall_left   = HOLD_CYCLES - 1;
				out_ch.ready <= 1'b0;
			end else if (rx_steady) begin
				out_ch.ready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 8) begin
					stall_left   = $urandom_range(0, 2);
					out_ch.ready <= 1'b0;
				end else if (r < 10) begin
					stall_left   = $urandom_range(15, 60);
					out_ch.ready <= 1'b0;
				end else begin
					out_ch.ready <= 1'b1;
				end
			end
		end
	end

	// Every point beat is checked against the oldest prediction.
	always @(posedge clk) begin
		point_t seen;
		if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			seen.point_x   = out_ch.point_x;
			seen.point_y   = out_ch.point_y;
			seen.pressure  = out_ch.pressure;
			seen.touched   = out_ch.touched;
			seen.cal_error = out_ch.cal_error;
			sb.check_point(seen);
		end
	end

	// Watchdog on the total run length.
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	// Stimulus: reset, directed samples, then random phases under varied calibrations.
	initial begin
		cal_regs_t     cal;
		logic [SW-1:0] t;
		int            per_phase;

		arst_n             = 1'b0;
		cfg_wr_en          = 1'b0;
		cfg_index          = CFG_X_CAL_LOW;
		cfg_wr_data        = '0;
		in_ch.valid        = 1'b0;
		in_ch.raw_x        = '0;
		in_ch.raw_y        = '0;
		in_ch.pressure_one = '0;
		in_ch.pressure_two = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset calibration: range ends, pressure extremes and the touch threshold.
		send_sample('{12'd0, 12'd0, 12'd0, 12'd0});
		send_sample('{12'd4095, 12'd4095, 12'd4095, 12'd4095});
		send_sample('{12'd2048, 12'd2048, 12'd0, 12'd4095});
		send_sample('{12'd2048, 12'd2048, 12'd4095, 12'd0});
		send_sample('{12'd2048, 12'd2048, 12'd300, 12'd4095});
		send_sample('{12'd2048, 12'd2048, 12'd301, 12'd4095});
		send_sample('{12'd1000, 12'd3000, 12'd2000, 12'd1000});
		send_sample('{12'hAAA, 12'h555, 12'h555, 12'hAAA});
		send_sample('{12'h555, 12'hAAA, 12'hAAA, 12'h555});

		// Zero span on the x axis.
		wait_drained();
		cal        = sb.regs;
		cal.x_lo   = 12'd2000;
		cal.x_hi   = 12'd2000;
		apply_config(cal);
		send_sample('{12'd2000, 12'd2000, 12'd3000, 12'd500});
		send_sample('{12'd100, 12'd4000, 12'd4095, 12'd0});

		// Reversed spans under the last bit-banged rotation.
		wait_drained();
		cal.x_lo     = 12'd3900;
		cal.x_hi     = 12'd200;
		cal.y_lo     = 12'd3800;
		cal.y_hi     = 12'd300;
		cal.rotation = ROT_3;
		cal.wiring   = WIRE_BITBANG;
		apply_config(cal);
		send_sample('{12'd1500, 12'd2500, 12'd1200, 12'd900});
		send_sample('{12'd0, 12'd4095, 12'd2000, 12'd2000});
		send_sample('{12'd4095, 12'd0, 12'd3000, 12'd100});

		// Zero screen size: nothing is ever in bounds.
		wait_drained();
		cal.width  = '0;
		cal.height = '0;
		apply_config(cal);
		send_sample('{12'd2048, 12'd2048, 12'd4000, 12'd100});
		send_sample('{12'd10, 12'd4000, 12'd2500, 12'd2000});

		// Random phases, each under its own calibration.
		per_phase = RANDOM_ITEMS / PHASES;
		for (int phase = 0; phase < PHASES; phase++) begin
			wait_drained();
			cal.x_lo = SW'($urandom_range(80, 600));
			cal.x_hi = SW'($urandom_range(3400, 4000));
			if ($urandom_range(0, 3) == 0) begin
				t        = cal.x_lo;
				cal.x_lo = cal.x_hi;
				cal.x_hi = t;
			end
			cal.y_lo = SW'($urandom_range(80, 600));
			cal.y_hi = SW'($urandom_range(3400, 4000));
			if ($urandom_range(0, 3) == 0) begin
				t        = cal.y_lo;
				cal.y_lo = cal.y_hi;
				cal.y_hi = t;
			end
			cal.rotation = 2'(phase % 4);
			cal.wiring   = ((phase / 4) % 2 == 0) ? WIRE_SPI : WIRE_BITBANG;
			cal.width    = SIZE_W'($urandom_range(64, 1024));
			cal.height   = SIZE_W'($urandom_range(48, 800));
			case (phase)
				2: begin
					// Full-scale spans, one of them reversed, and the largest screen.
					cal.x_lo   = SW'(FULL);
					cal.x_hi   = '0;
					cal.y_lo   = '0;
					cal.y_hi   = SW'(FULL);
					cal.width  = SIZE_W'(FULL);
					cal.height = SIZE_W'(FULL);
				end
				5: begin
					cal.width  = SIZE_W'(1);
					cal.height = SIZE_W'(1);
				end
				9: cal.y_hi = cal.y_lo;
				10: begin
					cal.width  = '0;
					cal.height = '0;
				end
				11: begin
					// A one-count span makes coordinates spill past sixteen bits.
					cal.x_lo   = 12'd2000;
					cal.x_hi   = 12'd2001;
					cal.width  = SIZE_W'(FULL);
					cal.height = SIZE_W'($urandom_range(1, FULL));
				end
				default: ;
			endcase
			apply_config(cal);

			for (int n = 0; n < per_phase; n++) begin
				if (n % 40 == 0) begin
					tx_steady = ($urandom_range(0, 3) == 0);
					rx_steady = ($urandom_range(0, 3) == 0);
				end
				// Long hold-off on the point side while samples keep coming.
				if (phase == 7 && n < 80)
					tx_steady = 1'b1;
				if (phase == 7 && n == 0)
					hold_req = 1'b1;
				if (n > 0 && $urandom_range(0, 199) == 0)
					wait_drained();
				send_sample('{rand_reading(), rand_reading(), rand_reading(), rand_reading()});
			end
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

[touch_sample_calibrator_unit.f]
rtl/tsc_pkg.sv
rtl/tsc_ifs.sv
rtl/tsc_front.sv
rtl/tsc_div.sv
rtl/tsc_out_buf.sv
rtl/touch_sample_calibrator_unit.sv
sim/tb_touch_sample_calibrator_unit.sv
